@@ sv/mci2t_pkg.sv @@
// ----------------------------------------------------------------------------
// mci2t_pkg
// Shared types, register indexes and constants of the motor current
// I2T watchdog.
// ----------------------------------------------------------------------------
package mci2t_pkg;

	// defaults of the top-level parameters
	localparam int JOINTS_DEF    = 4;
	localparam int FRAC_BITS_DEF = 16;

	// fixed field widths
	localparam int JOINT_W  = 2;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int SQ_W     = 31;
	localparam int LIMIT_W  = 32;
	localparam int SPIKE_W  = 64;
	localparam int ACTIVE_W = 3;
	localparam int LEVEL_W  = 31;
	localparam int LIMIT_CNT = 4;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPIKE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_I2T0   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_I2T1   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_I2T2   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_I2T3   = 3'd5;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;

	// leaky integrator window and the split of the reciprocal multiply
	localparam int WINDOW     = 1000;
	localparam int WINDOW_LOG = 10;
	localparam int PART_W     = 28;

	// front to back queue
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [JOINT_W-1:0] joint;
		logic               inr;     // joint exists in this build
		logic               act;     // joint is watched
		logic               spike;
		logic               oc_set;
		logic               i2t_set;
		logic [LIMIT_W-1:0] limit;
	} mci2t_ctl_t;

	typedef struct packed {
		mci2t_ctl_t       ctl;
		logic [MAG_W-1:0] mag;
	} mci2t_item_t;

	// ceil(2^k / WINDOW), worked out at elaboration
	function automatic logic [127:0] mci2t_recip(input int k);
		logic [127:0] p;
		p = 128'd1 << k;
		p = (p + 128'(WINDOW - 1)) / WINDOW;
		return p;
	endfunction

endpackage

@@ sv/mci2t_front.sv @@
// ----------------------------------------------------------------------------
// mci2t_front
// Holds the configuration, takes input transactions and classifies them:
// sample magnitude, spike check, active flag and the joint's I2T limit.
// ----------------------------------------------------------------------------
module mci2t_front #(
	parameter int JOINTS = mci2t_pkg::JOINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mci2t_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mci2t_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mci2t_pkg::JOINT_W-1:0]        joint,
	input  logic signed [mci2t_pkg::SAMPLE_W-1:0] current_sample,
	input  logic                                 overcurrent_bit_set,
	input  logic                                 i2t_bit_set,
	input  logic                                 q_full,
	output logic                                 q_push,
	output mci2t_pkg::mci2t_item_t               q_item
);
	import mci2t_pkg::*;

	logic [ACTIVE_W-1:0] active_q;
	logic [SPIKE_W-1:0]  spike_q;
	logic [LIMIT_W-1:0]  i2t_lim_q [LIMIT_CNT];

	logic [MAG_W-1:0]    mag;
	logic [MAG_W-1:0]    spike_lim;
	logic                inr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ACTIVE_RESET;
			spike_q   <= '1;
			i2t_lim_q <= '{default: '1};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE: active_q     <= cfg_data[ACTIVE_W-1:0];
				CFG_SPIKE:  spike_q      <= cfg_data;
				CFG_I2T0:   i2t_lim_q[0] <= cfg_data[LIMIT_W-1:0];
				CFG_I2T1:   i2t_lim_q[1] <= cfg_data[LIMIT_W-1:0];
				CFG_I2T2:   i2t_lim_q[2] <= cfg_data[LIMIT_W-1:0];
				CFG_I2T3:   i2t_lim_q[3] <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// -32768 comes out as 32768
	always_comb begin
		if (current_sample[SAMPLE_W-1])
			mag = MAG_W'(17'h10000) - {1'b0, current_sample};
		else
			mag = {1'b0, current_sample};
	end

	assign spike_lim = {1'b0, spike_q[SAMPLE_W*joint +: SAMPLE_W]};
	assign inr       = 32'(joint) < JOINTS;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item             = '0;
		q_item.mag         = mag;
		q_item.ctl.joint   = joint;
		q_item.ctl.inr     = inr;
		q_item.ctl.act     = inr && ({1'b0, joint} < active_q);
		q_item.ctl.spike   = mag > spike_lim;
		q_item.ctl.oc_set  = overcurrent_bit_set;
		q_item.ctl.i2t_set = i2t_bit_set;
		q_item.ctl.limit   = i2t_lim_q[joint];
	end

endmodule

@@ sv/mci2t_queue.sv @@
// ----------------------------------------------------------------------------
// mci2t_queue
// Short first-in first-out queue of classified samples between the front
// and the back part.
// ----------------------------------------------------------------------------
module mci2t_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mci2t_pkg::mci2t_item_t push_item,
	output logic                   full,
	input  logic                   pop,
	output logic                   head_valid,
	output mci2t_pkg::mci2t_item_t head_item
);
	import mci2t_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	mci2t_item_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign full       = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

@@ sv/mci2t_back.sv @@
// ----------------------------------------------------------------------------
// mci2t_back
// Integrator pipeline: square, difference, reciprocal multiply by 1/1000,
// write-back of the joint's level and the I2T compare into the result
// register. A watched joint with a sample in flight holds its later samples.
// ----------------------------------------------------------------------------
module mci2t_back #(
	parameter int JOINTS    = mci2t_pkg::JOINTS_DEF,
	parameter int FRAC_BITS = mci2t_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  mci2t_pkg::mci2t_item_t            head_item,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mci2t_pkg::JOINT_W-1:0]     joint_out,
	output logic                              spike_exceeded,
	output logic                              i2t_exceeded,
	output logic                              raise_overcurrent,
	output logic                              raise_i2t,
	output logic [mci2t_pkg::LEVEL_W-1:0]     filtered_level
);
	import mci2t_pkg::*;

	localparam int XW     = SQ_W + FRAC_BITS;      // level and |difference|
	localparam int K      = XW + WINDOW_LOG;
	localparam int M_W    = XW + 1;
	localparam int XH     = XW - PART_W;
	localparam int MH     = M_W - PART_W;
	localparam int PRW    = XW + M_W;
	localparam int QW     = XW - WINDOW_LOG + 1;
	localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam logic [M_W-1:0] RECIP = M_W'(mci2t_recip(K));
	localparam logic [PART_W-1:0] RECIP_LO = RECIP[PART_W-1:0];
	localparam logic [MH-1:0]     RECIP_HI = RECIP[M_W-1:PART_W];

	logic [XW-1:0]     lvl_q  [JOINTS];
	logic [JOINTS-1:0] busy_q;

	// stage registers
	logic              v_s1, v_s2, v_s3, v_s4;
	mci2t_ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [XW-1:0]     lvl_s1, lvl_s2, lvl_s3, lvl_s4;
	logic [SQ_W-1:0]   sq_s1;
	logic              neg_s2, neg_s3, neg_s4;
	logic [XW-1:0]     ax_s2;
	logic [2*PART_W-1:0]  pll_s3;
	logic [PART_W+MH-1:0] plh_s3;
	logic [XH+PART_W-1:0] phl_s3;
	logic [XH+MH-1:0]     phh_s3;
	logic [QW-1:0]     q_s4;

	// result register
	logic              out_v_q;
	logic [JOINT_W-1:0] joint_q;
	logic              spike_q, over_q, raise_oc_q, raise_i2t_q;
	logic [LEVEL_W-1:0] level_q;

	logic              adv_o, adv4, adv3, adv2, adv1;
	logic [JIDX_W-1:0] hidx, idx_s4;
	logic              hazard;
	logic [XW-1:0]     sq_fix;
	logic [PRW-1:0]    prod;
	logic [XW-1:0]     new_lvl;
	logic              over;
	logic              wb;

	assign adv_o = !out_v_q || !out_stall;
	assign adv4  = !v_s4 || adv_o;
	assign adv3  = !v_s3 || adv4;
	assign adv2  = !v_s2 || adv3;
	assign adv1  = !v_s1 || adv2;

	assign hidx   = head_item.ctl.joint[JIDX_W-1:0];
	assign hazard = head_item.ctl.inr && busy_q[hidx];
	assign pop    = head_valid && !hazard && adv1;

	assign sq_fix = {sq_s1, {FRAC_BITS{1'b0}}};

	assign prod = PRW'(pll_s3)
		+ (PRW'(plh_s3) << PART_W)
		+ (PRW'(phl_s3) << PART_W)
		+ (PRW'(phh_s3) << (2 * PART_W));

	// truncation toward zero: subtract the quotient when the level falls
	assign new_lvl = neg_s4 ? (lvl_s4 - XW'(q_s4)) : (lvl_s4 + XW'(q_s4));
	assign over    = {1'b0, new_lvl[XW-1:FRAC_BITS]} >= LIMIT_W'(ctl_s4.limit);
	assign idx_s4  = ctl_s4.joint[JIDX_W-1:0];
	assign wb      = adv_o && v_s4 && ctl_s4.act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
			busy_q  <= '0;
			lvl_q   <= '{default: '0};
		end else begin
			if (adv1)
				v_s1 <= pop;
			if (adv2)
				v_s2 <= v_s1;
			if (adv3)
				v_s3 <= v_s2;
			if (adv4)
				v_s4 <= v_s3;
			if (adv_o)
				out_v_q <= v_s4;
			if (pop && head_item.ctl.act)
				busy_q[hidx] <= 1'b1;
			if (wb) begin
				busy_q[idx_s4] <= 1'b0;
				lvl_q[idx_s4]  <= new_lvl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ctl_s1 <= head_item.ctl;
			sq_s1  <= SQ_W'(head_item.mag * head_item.mag);
			lvl_s1 <= head_item.ctl.inr ? lvl_q[hidx] : '0;
		end
		if (adv2) begin
			ctl_s2 <= ctl_s1;
			lvl_s2 <= lvl_s1;
			neg_s2 <= sq_fix < lvl_s1;
			ax_s2  <= (sq_fix < lvl_s1) ? (lvl_s1 - sq_fix) : (sq_fix - lvl_s1);
		end
		if (adv3) begin
			ctl_s3 <= ctl_s2;
			lvl_s3 <= lvl_s2;
			neg_s3 <= neg_s2;
			pll_s3 <= ax_s2[PART_W-1:0] * RECIP_LO;
			plh_s3 <= ax_s2[PART_W-1:0] * RECIP_HI;
			phl_s3 <= ax_s2[XW-1:PART_W] * RECIP_LO;
			phh_s3 <= ax_s2[XW-1:PART_W] * RECIP_HI;
		end
		if (adv4) begin
			ctl_s4 <= ctl_s3;
			lvl_s4 <= lvl_s3;
			neg_s4 <= neg_s3;
			q_s4   <= prod[K +: QW];
		end
		if (adv_o) begin
			joint_q     <= ctl_s4.joint;
			spike_q     <= ctl_s4.act && ctl_s4.spike;
			over_q      <= ctl_s4.act && over;
			raise_oc_q  <= ctl_s4.act && ctl_s4.spike && !ctl_s4.oc_set;
			raise_i2t_q <= ctl_s4.act && over && !ctl_s4.i2t_set;
			if (ctl_s4.act)
				level_q <= LEVEL_W'(new_lvl[XW-1:FRAC_BITS]);
			else
				level_q <= LEVEL_W'(lvl_s4[XW-1:FRAC_BITS]);
		end
	end

	assign out_valid         = out_v_q;
	assign joint_out         = joint_q;
	assign spike_exceeded    = spike_q;
	assign i2t_exceeded      = over_q;
	assign raise_overcurrent = raise_oc_q;
	assign raise_i2t         = raise_i2t_q;
	assign filtered_level    = level_q;

endmodule

@@ sv/motor_current_i2t_watchdog_unit.sv @@
// ----------------------------------------------------------------------------
// motor_current_i2t_watchdog_unit
// Per-joint current spike check and I2T leaky integrator watchdog.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  -------  ---------------------  ----------------------------------------
//  in       in_valid / in_stall    joint, current_sample,
//                                  overcurrent_bit_set, i2t_bit_set
//  out      out_valid / out_stall  joint_out, spike_exceeded, i2t_exceeded,
//                                  raise_overcurrent, raise_i2t,
//                                  filtered_level
//  cfg      cfg_we                 cfg_index, cfg_data
//
//  A sample waits at the queue head while a watched sample of its joint is
//  still between the queue and the result register, so a watched joint takes
//  no new sample before its last is through; other joints' samples can follow.
//  Each passes the queue, stages s1 to s4 and then the result register.
//  Reset clears the integrator levels and loads the register reset values.
//  out_stall holds the result register; the pipeline and the 4-entry queue
//  then fill before in_stall rises.
// ----------------------------------------------------------------------------
module motor_current_i2t_watchdog_unit #(
	parameter int JOINTS    = mci2t_pkg::JOINTS_DEF,
	parameter int FRAC_BITS = mci2t_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mci2t_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mci2t_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [mci2t_pkg::JOINT_W-1:0]         joint,
	input  logic signed [mci2t_pkg::SAMPLE_W-1:0] current_sample,
	input  logic                                  overcurrent_bit_set,
	input  logic                                  i2t_bit_set,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [mci2t_pkg::JOINT_W-1:0]         joint_out,
	output logic                                  spike_exceeded,
	output logic                                  i2t_exceeded,
	output logic                                  raise_overcurrent,
	output logic                                  raise_i2t,
	output logic [mci2t_pkg::LEVEL_W-1:0]         filtered_level
);
	import mci2t_pkg::*;

	logic        q_full;
	logic        q_push;
	mci2t_item_t q_item;
	logic        q_pop;
	logic        head_valid;
	mci2t_item_t head_item;

	mci2t_front #(
		.JOINTS(JOINTS)
	) u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.joint               (joint),
		.current_sample      (current_sample),
		.overcurrent_bit_set (overcurrent_bit_set),
		.i2t_bit_set         (i2t_bit_set),
		.q_full              (q_full),
		.q_push              (q_push),
		.q_item              (q_item)
	);

	mci2t_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	mci2t_back #(
		.JOINTS    (JOINTS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_valid        (head_valid),
		.head_item         (head_item),
		.pop               (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.joint_out         (joint_out),
		.spike_exceeded    (spike_exceeded),
		.i2t_exceeded      (i2t_exceeded),
		.raise_overcurrent (raise_overcurrent),
		.raise_i2t         (raise_i2t),
		.filtered_level    (filtered_level)
	);

endmodule
